/* hw/rtl/ptt_pkg.sv */
// Shared types and constants for the periodic timer table.
// Operation codes, controller states and the controller/datapath command
// and status bundles. No dependencies.
package ptt_pkg;

   // Fixed field widths of the request and response beats
   localparam int PERIOD_W    = 16;
   localparam int SLOT_FLD_W  = 4;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 8;

   // At most this many fire beats are reported for one tick
   localparam int MAX_FIRES  = 16;
   localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

   typedef logic [1:0] op_type;
   localparam op_type OP_TICK   = 2'd0;
   localparam op_type OP_INSERT = 2'd1;
   localparam op_type OP_REMOVE = 2'd2;
   localparam op_type OP_ENABLE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_APPLY = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic load_req;    // capture the request beat
      logic scan_start;  // reset the scan pointers and fire bookkeeping
      logic scan_run;    // advance the slot scan
      logic apply;       // perform insert/remove/enable and post its beat
      logic flush;       // post the final beat of a tick
   } cmd_type;

   typedef struct packed {
      logic in_is_tick;  // request on the port is a tick
      logic out_free;    // output register can take a beat this cycle
      logic scan_done;   // every slot has been visited
   } sts_type;

endpackage

/* hw/rtl/ptt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ptt_ctrl.sv */
// Controller state machine for the periodic timer table.
// Depends on ptt_pkg; drives the datapath through cmd_type, reads sts_type.
module ptt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ptt_pkg::sts_type sts,
   output ptt_pkg::cmd_type cmd
);

   ptt_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               if (sts.in_is_tick) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ptt_pkg::ST_SCAN;
               end else begin
                  state_in = ptt_pkg::ST_APPLY;
               end
            end
         end
         ptt_pkg::ST_APPLY: begin
            if (sts.out_free) begin
               cmd.apply = 1'b1;
               state_in  = ptt_pkg::ST_IDLE;
            end
         end
         ptt_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = ptt_pkg::ST_FLUSH;
            end
         end
         ptt_pkg::ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ptt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/ptt_dp.sv */
// Datapath of the periodic timer table: slot flags, period/count RAM,
// scan pipeline, fire holding register and output register.
// Depends on ptt_pkg and ptt_ram.
module ptt_dp #(
   parameter int NUM_SLOTS   = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ptt_pkg::cmd_type                 cmd,
   output ptt_pkg::sts_type                 sts,
   input  logic [ptt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ptt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [0:0]                       rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ISS_W   = $clog2(NUM_SLOTS + 1);
   localparam int CMP_W   = (COUNT_WIDTH > ptt_pkg::PERIOD_W) ? COUNT_WIDTH
                                                              : ptt_pkg::PERIOD_W;
   localparam int ENTRY_W = ptt_pkg::PERIOD_W + COUNT_WIDTH;

   // Latched request
   ptt_pkg::op_type                 req_op_ff, req_op_in;
   logic [ptt_pkg::SLOT_FLD_W-1:0]  req_slot_ff, req_slot_in;
   logic [ptt_pkg::PERIOD_W-1:0]    req_wait_ff, req_wait_in;
   logic                            req_en_ff, req_en_in;

   // Slot flags
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] enabled_ff, enabled_in;

   // Scan pipeline
   logic [ISS_W-1:0]  iss_ff, iss_in;
   logic              ev_valid_ff, ev_valid_in;
   logic [SLOT_W-1:0] ev_idx_ff, ev_idx_in;

   // Fire bookkeeping
   logic [ptt_pkg::FIRE_CNT_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic                           hold_valid_ff, hold_valid_in;
   logic [SLOT_W-1:0]              hold_slot_ff, hold_slot_in;

   // Output register
   logic                           out_valid_ff, out_valid_in;
   logic                           out_fired_ff, out_fired_in;
   logic [ptt_pkg::SLOT_FLD_W-1:0] out_slot_ff, out_slot_in;
   logic                           out_last_ff, out_last_in;

   // RAM port
   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [SLOT_W-1:0]  ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   // Evaluation terms
   logic [ptt_pkg::PERIOD_W-1:0]        ev_period;
   logic [COUNT_WIDTH-1:0]              ev_count;
   logic [COUNT_WIDTH-1:0]              ev_inc;
   logic                                ev_live;
   logic                                ev_hit;
   logic                                ev_report;
   logic                                stall;
   logic                                out_free;
   logic [SLOT_W+ptt_pkg::SLOT_FLD_W-1:0] a_ext;
   logic [SLOT_W-1:0]                   a_idx;
   logic                                a_in_range;
   logic [SLOT_W+ptt_pkg::SLOT_FLD_W-1:0] hold_ext;

   ptt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(NUM_SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign ev_period = ram_rdata[ENTRY_W-1:COUNT_WIDTH];
   assign ev_count  = ram_rdata[COUNT_WIDTH-1:0];
   assign ev_inc    = (ev_count == '1) ? ev_count : ev_count + 1'b1;
   assign ev_live   = ev_valid_ff && valid_ff[ev_idx_ff];
   assign ev_hit    = (ev_period != '0) && (CMP_W'(ev_inc) == CMP_W'(ev_period));
   assign ev_report = ev_live && ev_hit && enabled_ff[ev_idx_ff]
                      && (fire_cnt_ff < ptt_pkg::FIRE_CNT_W'(ptt_pkg::MAX_FIRES));
   assign out_free  = !out_valid_ff || rsp_tready;
   assign stall     = ev_report && hold_valid_ff && !out_free;

   assign a_ext      = {{SLOT_W{1'b0}}, req_slot_ff};
   assign a_idx      = a_ext[SLOT_W-1:0];
   assign a_in_range = 32'(req_slot_ff) < NUM_SLOTS;
   assign hold_ext   = {{ptt_pkg::SLOT_FLD_W{1'b0}}, hold_slot_ff};

   assign sts.in_is_tick = (req_tuser == ptt_pkg::OP_TICK);
   assign sts.out_free   = out_free;
   assign sts.scan_done  = (iss_ff == ISS_W'(NUM_SLOTS)) && !ev_valid_ff;

   always_comb begin
      req_op_in     = req_op_ff;
      req_slot_in   = req_slot_ff;
      req_wait_in   = req_wait_ff;
      req_en_in     = req_en_ff;
      valid_in      = valid_ff;
      enabled_in    = enabled_ff;
      iss_in        = iss_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      fire_cnt_in   = fire_cnt_ff;
      hold_valid_in = hold_valid_ff;
      hold_slot_in  = hold_slot_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_fired_in  = out_fired_ff;
      out_slot_in   = out_slot_ff;
      out_last_in   = out_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = ev_idx_ff;
      ram_wdata     = {ev_period, (ev_hit ? {COUNT_WIDTH{1'b0}} : ev_inc)};
      ram_raddr     = ev_idx_ff;

      if (cmd.load_req) begin
         req_op_in   = req_tuser;
         req_slot_in = req_tdata[3:0];
         req_wait_in = req_tdata[19:4];
         req_en_in   = req_tdata[20];
      end

      if (cmd.scan_start) begin
         iss_in        = '0;
         ev_valid_in   = 1'b0;
         fire_cnt_in   = '0;
         hold_valid_in = 1'b0;
      end

      if (cmd.scan_run && !stall) begin
         // Retire the slot in the evaluate stage
         if (ev_live) begin
            ram_we = 1'b1;
         end
         if (ev_report) begin
            fire_cnt_in   = fire_cnt_ff + 1'b1;
            hold_valid_in = 1'b1;
            hold_slot_in  = ev_idx_ff;
            if (hold_valid_ff) begin
               out_valid_in = 1'b1;
               out_fired_in = 1'b1;
               out_slot_in  = hold_ext[ptt_pkg::SLOT_FLD_W-1:0];
               out_last_in  = 1'b0;
            end
         end
         // Issue the next slot read
         if (iss_ff != ISS_W'(NUM_SLOTS)) begin
            ram_raddr   = iss_ff[SLOT_W-1:0];
            ev_valid_in = 1'b1;
            ev_idx_in   = iss_ff[SLOT_W-1:0];
            iss_in      = iss_ff + 1'b1;
         end else begin
            ev_valid_in = 1'b0;
         end
      end

      if (cmd.apply) begin
         if (a_in_range) begin
            case (req_op_ff)
               ptt_pkg::OP_INSERT: begin
                  valid_in[a_idx]   = 1'b1;
                  enabled_in[a_idx] = req_en_ff;
                  ram_we            = 1'b1;
                  ram_waddr         = a_idx;
                  ram_wdata         = {req_wait_ff, {COUNT_WIDTH{1'b0}}};
               end
               ptt_pkg::OP_REMOVE: begin
                  valid_in[a_idx]   = 1'b0;
                  enabled_in[a_idx] = 1'b0;
               end
               ptt_pkg::OP_ENABLE: begin
                  if (valid_ff[a_idx]) begin
                     enabled_in[a_idx] = req_en_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         out_valid_in = 1'b1;
         out_fired_in = 1'b0;
         out_slot_in  = '0;
         out_last_in  = 1'b1;
      end

      if (cmd.flush) begin
         out_valid_in = 1'b1;
         out_fired_in = hold_valid_ff;
         out_slot_in  = hold_valid_ff ? hold_ext[ptt_pkg::SLOT_FLD_W-1:0] : '0;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         enabled_ff    <= '0;
         iss_ff        <= '0;
         ev_valid_ff   <= 1'b0;
         fire_cnt_ff   <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         enabled_ff    <= enabled_in;
         iss_ff        <= iss_in;
         ev_valid_ff   <= ev_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_op_ff    <= req_op_in;
      req_slot_ff  <= req_slot_in;
      req_wait_ff  <= req_wait_in;
      req_en_ff    <= req_en_in;
      ev_idx_ff    <= ev_idx_in;
      hold_slot_ff <= hold_slot_in;
      out_fired_ff <= out_fired_in;
      out_slot_ff  <= out_slot_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ptt_pkg::RSP_TDATA_W - ptt_pkg::SLOT_FLD_W){1'b0}}, out_slot_ff};
   assign rsp_tuser  = out_fired_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* hw/rtl/periodic_timer_table.sv */
// Top level of the periodic timer table: controller plus datapath.
// Depends on ptt_pkg, ptt_ctrl, ptt_dp (and ptt_ram through ptt_dp).
// Usage:
//   The req_ channel carries one command per beat: tick, insert slot,
//   remove slot or set slot enable (selected by req_tuser). The rsp_
//   channel returns the beats each command causes, the final one marked
//   by rsp_tlast. A tick returns one beat per enabled slot whose period
//   elapsed, in ascending slot order (at most sixteen), or one beat with
//   rsp_tuser low when nothing fired. Every other command returns one
//   beat with rsp_tuser low and rsp_tlast high.
// Sequence:
//   Insert, remove and set enable: accept, then apply and load the
//   result beat. A tick: accept, one RAM read per slot, the RAM read
//   latency, an end-of-scan step and the final beat. Output stalls
//   lengthen both.
// Reset:
//   Synchronous reset frees every slot and empties the output register.
//   No clearing pass is needed; a scan ignores a slot's period and
//   count until its insert has written them.
// Backpressure:
//   A stalled rsp_ side holds the current beat; the tick scan pauses
//   only when a second fire is ready while the output register is full.
module periodic_timer_table #(
   parameter int NUM_SLOTS   = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata: slot [3:0], wait_ticks [19:4], enable [20], zero [23:21]
   input  logic [ptt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: operation [1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: fired_slot [3:0], zero [7:4]
   output logic [ptt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: fired [0]
   output logic [0:0]                      rsp_tuser,
   output logic                            rsp_tlast
);

   ptt_pkg::cmd_type cmd;
   ptt_pkg::sts_type sts;

   // Sequence accept, apply/scan and the closing beat
   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold slot state, run the count scan and drive the result beats
   ptt_dp #(
      .NUM_SLOTS  (NUM_SLOTS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
